### sv/eul_pkg.sv
// Shared types, constants and helpers for the Euler motion step block.
// Used by eul_muldiv, eul_core and euler_motion_step_3d_top; no dependencies.
package eul_pkg;

  localparam int WORD_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DT_FRAC        = 16;
  localparam int DT_BITS        = 16;
  localparam int OUT_BITS       = 32;
  localparam int MASS_BITS      = 31;
  localparam int GRAV_INT_BITS  = 4;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 31;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MASS    = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRAVITY = 1'd1;

  localparam logic [MASS_BITS-1:0] MASS_RESET = 31'd65536;
  localparam logic [1:0]           AX_LAST    = 2'd2;
  localparam logic [1:0]           AX_Y       = 2'd1;

  function automatic int max_i(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DCMP,
    MD_RADD,
    MD_FIN
  } md_state_t;

  typedef enum logic {
    MD_OP_MUL,
    MD_OP_DIV
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
    logic   bneg;
    logic   sh_frac;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } md_rsp_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_PUSH,
    CS_DRAG_OP,
    CS_DRAG_ADD,
    CS_GRAV_GO,
    CS_GRAV_WAIT,
    CS_DIV_GO,
    CS_DIV_WAIT,
    CS_AMUL_GO,
    CS_AMUL_WAIT,
    CS_PMUL_GO,
    CS_PMUL_WAIT,
    CS_DECAY,
    CS_DONE
  } core_state_t;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_FRC,
    DST_VEL,
    DST_POS
  } sa_dst_t;

  typedef enum logic [1:0] {
    SRC_PUSH,
    SRC_DRAG,
    SRC_MD
  } sa_src_t;

  typedef struct packed {
    logic [MASS_BITS-1:0] mass;
    logic                 gravity_enable;
  } core_cfg_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
    logic sat;
  } core_sts_t;

endpackage

### sv/eul_muldiv.sv
// Shared iterative arithmetic unit: shift-add multiply and restoring divide on one adder,
// with round-to-nearest and signed saturation. Depends on eul_pkg.
module eul_muldiv
  import eul_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  md_req_t                                                req,
  input  logic signed [max_i(WORD_BITS, OUT_BITS)-1:0]           opa,
  input  logic [max_i(DT_FRAC, FRAC_BITS + GRAV_INT_BITS)-1:0]   opb,
  input  logic [MASS_BITS-1:0]                                   divisor,
  output md_rsp_t                                                rsp,
  output logic signed [WORD_BITS-1:0]                            res
);

  localparam int XW   = max_i(WORD_BITS, OUT_BITS);
  localparam int MBW  = max_i(DT_FRAC, FRAC_BITS + GRAV_INT_BITS);
  localparam int PW   = XW + MBW;
  localparam int DW   = WORD_BITS + FRAC_BITS;
  localparam int AW   = max_i(PW, DW) + 1;
  localparam int NMAX = max_i(MBW, DW);
  localparam int CW   = $clog2(NMAX);

  localparam logic [AW-1:0] ONE_A    = {{(AW-1){1'b0}}, 1'b1};
  localparam logic [AW-1:0] HALF_F   = ONE_A << (FRAC_BITS - 1);
  localparam logic [AW-1:0] HALF_DT  = ONE_A << (DT_FRAC - 1);
  localparam logic [AW-1:0] LIM_NEG  = ONE_A << (WORD_BITS - 1);
  localparam logic [AW-1:0] LIM_POS  = LIM_NEG - ONE_A;
  localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] W_MIN = ~W_MAX;

  md_state_t state, state_next;

  logic [AW-1:0]        acc;
  logic [XW-1:0]        xmag;
  logic [MBW-1:0]       mb;
  logic [DW-1:0]        dvd;
  logic [MASS_BITS-1:0] rem;
  logic [CW-1:0]        cnt;
  logic                 op_div;
  logic                 neg;
  logic                 shf;
  logic                 rnd;
  logic                 done_q;
  logic                 sat_q;

  logic [XW-1:0]        a_mag;
  logic [AW-1:0]        add_a;
  logic [AW-1:0]        add_b;
  logic                 add_c;
  logic [AW:0]          sum;
  logic [MASS_BITS:0]   div_t;
  logic [AW-1:0]        mag_fin;
  logic                 over;
  logic signed [WORD_BITS-1:0] res_next;

  assign a_mag = opa[XW-1] ? XW'(-opa) : XW'(opa);
  assign div_t = {rem, dvd[DW-1]};

  // one adder serves every step; the divide compares through the carry out
  always_comb begin
    add_a = '0;
    add_b = '0;
    add_c = 1'b0;
    case (state)
      MD_MUL: begin
        add_a = acc << 1;
        add_b = mb[MBW-1] ? AW'(xmag) : '0;
      end
      MD_DIV: begin
        add_a = AW'(div_t);
        add_b = ~AW'(divisor);
        add_c = 1'b1;
      end
      MD_DCMP: begin
        add_a = AW'({rem, 1'b0});
        add_b = ~AW'(divisor);
        add_c = 1'b1;
      end
      MD_RADD: begin
        add_a = acc;
        add_b = op_div ? AW'(rnd) : (shf ? HALF_F : HALF_DT);
      end
      default: ;
    endcase
    sum = {1'b0, add_a} + {1'b0, add_b} + (AW + 1)'(add_c);
  end

  always_comb begin
    if (op_div) begin
      mag_fin = acc;
    end else if (shf) begin
      mag_fin = acc >> FRAC_BITS;
    end else begin
      mag_fin = acc >> DT_FRAC;
    end
    over = neg ? (mag_fin > LIM_NEG) : (mag_fin > LIM_POS);
    if (over) begin
      res_next = neg ? W_MIN : W_MAX;
    end else if (neg) begin
      res_next = -$signed(mag_fin[WORD_BITS-1:0]);
    end else begin
      res_next = $signed(mag_fin[WORD_BITS-1:0]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      MD_IDLE: begin
        if (req.start) begin
          state_next = (req.op == MD_OP_DIV) ? MD_DIV : MD_MUL;
        end
      end
      MD_MUL: begin
        if (cnt == '0) begin
          state_next = MD_RADD;
        end
      end
      MD_DIV: begin
        if (cnt == '0) begin
          state_next = MD_DCMP;
        end
      end
      MD_DCMP: state_next = MD_RADD;
      MD_RADD: state_next = MD_FIN;
      MD_FIN:  state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= MD_IDLE;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
    end else begin
      state  <= state_next;
      done_q <= (state == MD_FIN);
      if (state == MD_FIN) begin
        sat_q <= over;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        if (req.start) begin
          op_div <= (req.op == MD_OP_DIV);
          neg    <= opa[XW-1] ^ req.bneg;
          shf    <= req.sh_frac;
          acc    <= '0;
          xmag   <= a_mag;
          mb     <= opb;
          dvd    <= DW'(a_mag[WORD_BITS-1:0]) << FRAC_BITS;
          rem    <= '0;
          cnt    <= (req.op == MD_OP_DIV) ? CW'(DW - 1) : CW'(MBW - 1);
        end
      end
      MD_MUL: begin
        acc <= sum[AW-1:0];
        mb  <= mb << 1;
        cnt <= cnt - 1'b1;
      end
      MD_DIV: begin
        // restore when the trial subtract borrows
        rem <= sum[AW] ? sum[MASS_BITS-1:0] : div_t[MASS_BITS-1:0];
        acc <= {acc[AW-2:0], sum[AW]};
        dvd <= dvd << 1;
        cnt <= cnt - 1'b1;
      end
      MD_DCMP: rnd <= sum[AW];
      MD_RADD: acc <= sum[AW-1:0];
      MD_FIN:  res <= res_next;
      default: ;
    endcase
  end

  assign rsp.busy = (state != MD_IDLE);
  assign rsp.done = done_q;
  assign rsp.sat  = sat_q;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("muldiv done longer than one cycle");

  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    (rsp.done && rsp.sat) |-> (res == W_MAX || res == W_MIN))
    else $error("saturated result not at a word limit");

endmodule

### sv/eul_core.sv
// Step sequencer and state vectors: push, drag and gravity if enabled, divide and two
// multiplies per axis on the shared unit, then force decay. Uses eul_pkg, eul_muldiv.
module eul_core
  import eul_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DT_BITS-1:0]          dt_in,
  input  logic signed [OUT_BITS-1:0]  push_in [3],
  input  core_cfg_t                   cfg,
  input  logic                        out_free,
  output core_sts_t                   sts,
  output logic signed [WORD_BITS-1:0] pos [3],
  output logic signed [WORD_BITS-1:0] vel [3],
  output logic signed [WORD_BITS-1:0] frc [3]
);

  localparam int XW  = max_i(WORD_BITS, OUT_BITS);
  localparam int MBW = max_i(DT_FRAC, FRAC_BITS + GRAV_INT_BITS);
  localparam int SW  = XW + 1;

  localparam logic [63:0] GRAV_FULL = ((64'd981 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [MBW-1:0] GRAV_K = GRAV_FULL[MBW-1:0];
  localparam logic signed [WORD_BITS-1:0] HALF_W =
    {{(WORD_BITS-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] W_MIN = ~W_MAX;
  localparam logic signed [SW-1:0] S_MAX = {{(SW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = ~S_MAX;

  core_state_t state, state_next;
  logic [1:0]  ax, ax_next;

  logic [DT_BITS-1:0]          dt;
  logic signed [OUT_BITS-1:0]  push [3];
  logic signed [WORD_BITS-1:0] drag;
  logic signed [WORD_BITS-1:0] accel;
  logic                        sat_flag;

  logic [MASS_BITS-1:0]        mass_eff;
  md_req_t                     md_req;
  md_rsp_t                     md_rsp;
  logic signed [XW-1:0]        md_opa;
  logic [MBW-1:0]              md_opb;
  logic signed [WORD_BITS-1:0] md_res;

  sa_dst_t                     sa_dst;
  sa_src_t                     sa_src;
  logic [1:0]                  sa_idx;
  logic                        res_pulse;
  logic signed [WORD_BITS-1:0] sa_a;
  logic signed [XW-1:0]        sa_b;
  logic signed [SW-1:0]        sa_sum;
  logic                        sa_hi;
  logic                        sa_lo;
  logic signed [WORD_BITS-1:0] sa_res;

  logic signed [WORD_BITS-1:0] v_cur;
  logic [WORD_BITS-1:0]        v_mag;
  logic [WORD_BITS-1:0]        v_half;
  logic signed [WORD_BITS-1:0] drag_val;

  // a zero mass register acts as the smallest mass
  assign mass_eff = (cfg.mass == '0) ? {{(MASS_BITS-1){1'b0}}, 1'b1} : cfg.mass;

  eul_muldiv #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_muldiv (
    .clk     (clk),
    .rst     (rst),
    .req     (md_req),
    .opa     (md_opa),
    .opb     (md_opb),
    .divisor (mass_eff),
    .rsp     (md_rsp),
    .res     (md_res)
  );

  // drag is minus half the velocity, rounded away from zero on the magnitude
  always_comb begin
    v_cur  = vel[ax];
    v_mag  = v_cur[WORD_BITS-1] ? WORD_BITS'(-v_cur) : WORD_BITS'(v_cur);
    v_half = (v_mag >> 1) + WORD_BITS'(v_mag[0]);
    drag_val = (!v_cur[WORD_BITS-1] && (v_cur != '0)) ? -$signed(v_half) : $signed(v_half);
  end

  always_comb begin
    case (sa_dst)
      DST_VEL: sa_a = vel[sa_idx];
      DST_POS: sa_a = pos[sa_idx];
      default: sa_a = frc[sa_idx];
    endcase
    case (sa_src)
      SRC_PUSH: sa_b = XW'(push[sa_idx]);
      SRC_DRAG: sa_b = XW'(drag);
      default:  sa_b = XW'(md_res);
    endcase
    sa_sum = SW'(sa_a) + SW'(sa_b);
    sa_hi  = (sa_sum > S_MAX);
    sa_lo  = (sa_sum < S_MIN);
    if (sa_hi) begin
      sa_res = W_MAX;
    end else if (sa_lo) begin
      sa_res = W_MIN;
    end else begin
      sa_res = sa_sum[WORD_BITS-1:0];
    end
  end

  always_comb begin
    state_next = state;
    ax_next    = ax;
    case (state)
      CS_IDLE: begin
        if (start) begin
          state_next = CS_PUSH;
          ax_next    = '0;
        end
      end
      CS_PUSH: begin
        if (ax == AX_LAST) begin
          ax_next    = '0;
          state_next = cfg.gravity_enable ? CS_DRAG_OP : CS_DIV_GO;
        end else begin
          ax_next = ax + 1'b1;
        end
      end
      CS_DRAG_OP: state_next = CS_DRAG_ADD;
      CS_DRAG_ADD: begin
        if (ax == AX_LAST) begin
          ax_next    = '0;
          state_next = CS_GRAV_GO;
        end else begin
          ax_next    = ax + 1'b1;
          state_next = CS_DRAG_OP;
        end
      end
      CS_GRAV_GO: state_next = CS_GRAV_WAIT;
      CS_GRAV_WAIT: begin
        if (md_rsp.done) begin
          state_next = CS_DIV_GO;
        end
      end
      CS_DIV_GO: state_next = CS_DIV_WAIT;
      CS_DIV_WAIT: begin
        if (md_rsp.done) begin
          state_next = CS_AMUL_GO;
        end
      end
      CS_AMUL_GO: state_next = CS_AMUL_WAIT;
      CS_AMUL_WAIT: begin
        if (md_rsp.done) begin
          state_next = CS_PMUL_GO;
        end
      end
      CS_PMUL_GO: state_next = CS_PMUL_WAIT;
      CS_PMUL_WAIT: begin
        if (md_rsp.done) begin
          if (ax == AX_LAST) begin
            ax_next    = '0;
            state_next = CS_DECAY;
          end else begin
            ax_next    = ax + 1'b1;
            state_next = CS_DIV_GO;
          end
        end
      end
      CS_DECAY: state_next = CS_DONE;
      CS_DONE: begin
        if (out_free) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    md_req    = '0;
    md_opa    = '0;
    md_opb    = '0;
    sa_dst    = DST_NONE;
    sa_src    = SRC_PUSH;
    sa_idx    = ax;
    res_pulse = 1'b0;
    case (state)
      CS_PUSH: sa_dst = DST_FRC;
      CS_DRAG_ADD: begin
        sa_dst = DST_FRC;
        sa_src = SRC_DRAG;
      end
      CS_GRAV_GO: begin
        md_req.start   = 1'b1;
        md_req.op      = MD_OP_MUL;
        md_req.bneg    = 1'b1;
        md_req.sh_frac = 1'b1;
        md_opa         = XW'($signed({1'b0, mass_eff}));
        md_opb         = GRAV_K;
      end
      CS_GRAV_WAIT: begin
        if (md_rsp.done) begin
          sa_dst = DST_FRC;
          sa_src = SRC_MD;
          sa_idx = AX_Y;
        end
      end
      CS_DIV_GO: begin
        md_req.start = 1'b1;
        md_req.op    = MD_OP_DIV;
        md_opa       = XW'(frc[ax]);
      end
      CS_AMUL_GO: begin
        md_req.start = 1'b1;
        md_req.op    = MD_OP_MUL;
        md_opa       = XW'(accel);
        md_opb       = MBW'(dt);
      end
      CS_AMUL_WAIT: begin
        if (md_rsp.done) begin
          sa_dst = DST_VEL;
          sa_src = SRC_MD;
        end
      end
      CS_PMUL_GO: begin
        md_req.start = 1'b1;
        md_req.op    = MD_OP_MUL;
        md_opa       = XW'(vel[ax]);
        md_opb       = MBW'(dt);
      end
      CS_PMUL_WAIT: begin
        if (md_rsp.done) begin
          sa_dst = DST_POS;
          sa_src = SRC_MD;
        end
      end
      CS_DONE: res_pulse = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CS_IDLE;
      ax       <= '0;
      sat_flag <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        frc[i] <= '0;
        vel[i] <= '0;
        pos[i] <= '0;
      end
    end else begin
      state <= state_next;
      ax    <= ax_next;
      if (state == CS_IDLE && start) begin
        sat_flag <= 1'b0;
      end else if ((sa_dst != DST_NONE && (sa_hi || sa_lo)) || (md_rsp.done && md_rsp.sat)) begin
        sat_flag <= 1'b1;
      end
      case (sa_dst)
        DST_FRC: frc[sa_idx] <= sa_res;
        DST_VEL: vel[sa_idx] <= sa_res;
        DST_POS: pos[sa_idx] <= sa_res;
        default: ;
      endcase
      // move each nonzero force half a unit toward zero, crossing it if small
      if (state == CS_DECAY) begin
        for (int i = 0; i < 3; i++) begin
          if (frc[i] > 0) begin
            frc[i] <= frc[i] - HALF_W;
          end else if (frc[i] < 0) begin
            frc[i] <= frc[i] + HALF_W;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == CS_IDLE && start) begin
      dt   <= dt_in;
      push <= push_in;
    end
    if (state == CS_DRAG_OP) begin
      drag <= drag_val;
    end
    if (state == CS_DIV_WAIT && md_rsp.done) begin
      accel <= md_res;
    end
  end

  assign sts.busy      = (state != CS_IDLE);
  assign sts.res_valid = res_pulse;
  assign sts.sat       = sat_flag;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    md_req.start |-> !md_rsp.busy)
    else $error("shared unit started while busy");

  a_result_ends: assert property (@(posedge clk) disable iff (rst)
    sts.res_valid |=> !sts.busy)
    else $error("sequencer still busy after result transfer");

  a_decay_moves: assert property (@(posedge clk) disable iff (rst)
    (state == CS_DECAY) |=> (frc[0] != $past(frc[0]) || $past(frc[0]) == '0))
    else $error("nonzero force not decayed");

endmodule

### sv/euler_motion_step_3d_top.sv
// Top level of the three-axis Euler motion step: configuration registers, input
// handshake and output register. Depends on eul_pkg and eul_core.
//
//   channel   direction   handshake          payload
//   cfg       in          cfg_we             cfg_index, cfg_data (mass, gravity_enable)
//   in        in          in_valid/in_stall  time_step, push_x, push_y, push_z
//   out       out         out_valid/out_stall pos_*, vel_*, frc_*, saturated
//
// Each tick runs per axis a divide and two multiplies, plus one gravity multiply with
// gravity on, on the one-bit-per-cycle shared multiply/divide unit. in_stall stays high
// while a tick is in progress; the next tick can transfer in the cycle after the result
// goes to the output register. A result held by out_stall keeps the output register;
// a finished tick waits behind it. Synchronous reset clears the state vectors to zero
// and sets mass to 65536 (1.0 at the default FRAC_BITS), gravity off.
module euler_motion_step_3d_top
  import eul_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [DT_BITS-1:0]         time_step,
  input  logic signed [OUT_BITS-1:0] push_x,
  input  logic signed [OUT_BITS-1:0] push_y,
  input  logic signed [OUT_BITS-1:0] push_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_BITS-1:0] pos_x,
  output logic signed [OUT_BITS-1:0] pos_y,
  output logic signed [OUT_BITS-1:0] pos_z,
  output logic signed [OUT_BITS-1:0] vel_x,
  output logic signed [OUT_BITS-1:0] vel_y,
  output logic signed [OUT_BITS-1:0] vel_z,
  output logic signed [OUT_BITS-1:0] frc_x,
  output logic signed [OUT_BITS-1:0] frc_y,
  output logic signed [OUT_BITS-1:0] frc_z,
  output logic                       saturated
);

  localparam int EW = max_i(WORD_BITS, OUT_BITS);

  core_cfg_t                   cfg;
  core_sts_t                   sts;
  logic                        in_xfer;
  logic                        out_free;
  logic signed [OUT_BITS-1:0]  push_arr [3];
  logic signed [WORD_BITS-1:0] pos_w [3];
  logic signed [WORD_BITS-1:0] vel_w [3];
  logic signed [WORD_BITS-1:0] frc_w [3];
  logic signed [EW-1:0]        pos_e [3];
  logic signed [EW-1:0]        vel_e [3];
  logic signed [EW-1:0]        frc_e [3];

  assign push_arr[0] = push_x;
  assign push_arr[1] = push_y;
  assign push_arr[2] = push_z;

  assign in_stall = sts.busy;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mass           <= MASS_RESET;
      cfg.gravity_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASS:    cfg.mass           <= cfg_data[MASS_BITS-1:0];
        CFG_GRAVITY: cfg.gravity_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  eul_core #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (in_xfer),
    .dt_in    (time_step),
    .push_in  (push_arr),
    .cfg      (cfg),
    .out_free (out_free),
    .sts      (sts),
    .pos      (pos_w),
    .vel      (vel_w),
    .frc      (frc_w)
  );

  // words narrower than the port are sign-extended, wider ones give their low bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_e[i] = EW'(pos_w[i]);
      vel_e[i] = EW'(vel_w[i]);
      frc_e[i] = EW'(frc_w[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sts.res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.res_valid) begin
      pos_x     <= pos_e[0][OUT_BITS-1:0];
      pos_y     <= pos_e[1][OUT_BITS-1:0];
      pos_z     <= pos_e[2][OUT_BITS-1:0];
      vel_x     <= vel_e[0][OUT_BITS-1:0];
      vel_y     <= vel_e[1][OUT_BITS-1:0];
      vel_z     <= vel_e[2][OUT_BITS-1:0];
      frc_x     <= frc_e[0][OUT_BITS-1:0];
      frc_y     <= frc_e[1][OUT_BITS-1:0];
      frc_z     <= frc_e[2][OUT_BITS-1:0];
      saturated <= sts.sat;
    end
  end

endmodule
